>>> rtl/triangle_midpoint_subdivider_macros.svh
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider assertion macros
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_MACROS_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define TMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider package
// Beat types and default constants.
// ----------------------------------------------------------------------------
package tms_pkg;

    localparam int FRAC_BITS_DEF          = 14;
    localparam int VERTEX_NUMBER_BITS_DEF = 16;
    localparam int MAG_MAX                = 32767;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] nrm_x;
        logic signed [15:0] nrm_y;
        logic signed [15:0] nrm_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_pos_x;
        logic signed [15:0] out_pos_y;
        logic signed [15:0] out_pos_z;
        logic signed [15:0] out_nrm_x;
        logic signed [15:0] out_nrm_y;
        logic signed [15:0] out_nrm_z;
        logic signed [15:0] out_tex_u;
        logic signed [15:0] out_tex_v;
        logic        [15:0] vertex_number;
        logic               last_of_triangle;
    } t_out_item;

    typedef struct packed {
        logic project_to_sphere;
    } t_cfg_item;

endpackage

>>> rtl/tms_if.sv
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider stream interface
// Valid/ready channel carrying one beat of type t_data.
// ----------------------------------------------------------------------------
interface tms_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/triangle_midpoint_subdivider.sv
// Timing: the first and second corners are each stored on acceptance.
// After the third corner the midpoints are formed, then the normal is found by a
//   cross product and normalized (shared multiplier, bit-serial square root,
//   bit-serial divider); sphere mode first normalizes each of the three midpoints.
// A new triangle is refused until all six output beats of the last one are taken.
// Reset: synchronous active low; corner count, vertex number and mode clear.
// ----------------------------------------------------------------------------
// Triangle midpoint subdivider
// Collects three corners and emits the corners and their three midpoints.
// ----------------------------------------------------------------------------
`include "triangle_midpoint_subdivider_macros.svh"
module triangle_midpoint_subdivider #(
    parameter int FRAC_BITS          = tms_pkg::FRAC_BITS_DEF,
    parameter int VERTEX_NUMBER_BITS = tms_pkg::VERTEX_NUMBER_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tms_if.sink    i_in,
    tms_if.source  o_out,
    tms_if.sink    i_cfg
);

    localparam int VW    = 35;              // cross product component width
    localparam int MW    = 31;              // magnitude after prescale
    localparam int NUM_W = MW + FRAC_BITS;  // dividend width
    localparam int J_W   = $clog2(NUM_W);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MID   = 4'd1;
    localparam logic [3:0] ST_LOADV = 4'd2;
    localparam logic [3:0] ST_NABS  = 4'd3;
    localparam logic [3:0] ST_NSQ   = 4'd4;
    localparam logic [3:0] ST_NSQRT = 4'd5;
    localparam logic [3:0] ST_NDIV  = 4'd6;
    localparam logic [3:0] ST_NDONE = 4'd7;
    localparam logic [3:0] ST_CROSS = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    localparam logic [1:0] SEL_NRM = 2'd3;

    logic [3:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_sphere, n_sphere;
    logic       r_sph_s, n_sph_s;
    logic [VERTEX_NUMBER_BITS-1:0] r_vnum, n_vnum;
    logic [2:0] r_ek, n_ek;

    tms_pkg::t_in_item r_c0, n_c0, r_c1, n_c1, r_c2, n_c2;

    logic signed [15:0] r_mid  [3][3];
    logic signed [15:0] n_mid  [3][3];
    logic signed [15:0] r_nrm  [3];
    logic signed [15:0] n_nrm  [3];
    logic signed [15:0] r_nout [3];
    logic signed [15:0] n_nout [3];
    logic signed [VW-1:0] r_v [3];
    logic signed [VW-1:0] n_v [3];
    logic [MW-1:0] r_mag [3];
    logic [MW-1:0] n_mag [3];
    logic [2:0]    r_neg, n_neg;
    logic [1:0]    r_nsel, n_nsel;
    logic [1:0]    r_idx, n_idx;
    logic [J_W-1:0] r_j, n_j;
    logic [63:0]   r_s, n_s;
    logic [33:0]   r_rem, n_rem;
    logic [31:0]   r_root, n_root;
    logic [NUM_W-1:0] r_num, n_num, r_quo, n_quo;
    logic [31:0]   r_drem, n_drem;
    logic signed [65:0] r_prod;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic signed [16:0] w_d1 [3];
    logic signed [16:0] w_d2 [3];

    assign w_prod = w_ma * w_mb;

    function automatic logic signed [15:0] half_floor(logic signed [15:0] p,
                                                      logic signed [15:0] q);
        logic signed [16:0] sum;
        sum = 17'(p) + 17'(q);
        return sum[16:1];
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d1[i] = 17'(r_mid[1][i]) - 17'(r_mid[0][i]);
            w_d2[i] = 17'(r_mid[2][i]) - 17'(r_mid[0][i]);
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == ST_NSQ) begin
            w_ma = {2'b00, r_mag[r_idx]};
            w_mb = {2'b00, r_mag[r_idx]};
        end else if (r_state == ST_CROSS) begin
            case (r_j[2:0])
                3'd0: begin w_ma = 33'(w_d1[1]); w_mb = 33'(w_d2[2]); end
                3'd1: begin w_ma = 33'(w_d1[2]); w_mb = 33'(w_d2[1]); end
                3'd2: begin w_ma = 33'(w_d1[2]); w_mb = 33'(w_d2[0]); end
                3'd3: begin w_ma = 33'(w_d1[0]); w_mb = 33'(w_d2[2]); end
                3'd4: begin w_ma = 33'(w_d1[0]); w_mb = 33'(w_d2[1]); end
                3'd5: begin w_ma = 33'(w_d1[1]); w_mb = 33'(w_d2[0]); end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end
    end

    always_comb begin
        logic [VW-1:0] mag [3];
        logic [VW-1:0] mx;
        int            kk;
        logic [35:0]   sq_t;
        logic [35:0]   sq_trial;
        logic [32:0]   dv_t;
        logic [NUM_W-1:0] quo;
        logic [15:0]   qm;
        logic [63:0]   s_fin;
        logic [2:0]    pk;

        n_state = r_state; n_cnt = r_cnt; n_sphere = r_sphere; n_sph_s = r_sph_s;
        n_vnum = r_vnum; n_ek = r_ek;
        n_c0 = r_c0; n_c1 = r_c1; n_c2 = r_c2;
        n_mid = r_mid; n_nrm = r_nrm; n_nout = r_nout; n_v = r_v; n_mag = r_mag;
        n_neg = r_neg; n_nsel = r_nsel; n_idx = r_idx; n_j = r_j; n_s = r_s;
        n_rem = r_rem; n_root = r_root; n_num = r_num; n_quo = r_quo; n_drem = r_drem;

        mx = '0;
        kk = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = r_v[i][VW-1] ? VW'(-r_v[i]) : VW'(r_v[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        for (int s = 4; s >= 0; s--) begin
            if ((mx >> s) < (VW'(1) << MW)) kk = s;
        end
        sq_t     = {r_rem, r_s[63:62]};
        sq_trial = {2'b00, r_root, 2'b01};
        dv_t     = {r_drem, r_num[NUM_W-1]};
        quo      = {r_quo[NUM_W-2:0], (dv_t >= {1'b0, r_root})};
        qm       = (quo > NUM_W'(tms_pkg::MAG_MAX)) ? 16'(tms_pkg::MAG_MAX) : quo[15:0];
        s_fin    = r_s + 64'(r_prod);
        pk       = r_j[2:0] - 3'd1;

        if (i_cfg.valid) n_sphere = i_cfg.data.project_to_sphere;

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    case (r_cnt)
                        2'd0: begin n_c0 = i_in.data; n_cnt = 2'd1; end
                        2'd1: begin n_c1 = i_in.data; n_cnt = 2'd2; end
                        default: begin
                            n_c2 = i_in.data;
                            n_cnt = 2'd0;
                            n_sph_s = r_sphere;
                            n_state = ST_MID;
                        end
                    endcase
                end
            end
            ST_MID: begin
                n_mid[0][0] = half_floor(r_c0.pos_x, r_c1.pos_x);
                n_mid[0][1] = half_floor(r_c0.pos_y, r_c1.pos_y);
                n_mid[0][2] = half_floor(r_c0.pos_z, r_c1.pos_z);
                n_mid[1][0] = half_floor(r_c1.pos_x, r_c2.pos_x);
                n_mid[1][1] = half_floor(r_c1.pos_y, r_c2.pos_y);
                n_mid[1][2] = half_floor(r_c1.pos_z, r_c2.pos_z);
                n_mid[2][0] = half_floor(r_c2.pos_x, r_c0.pos_x);
                n_mid[2][1] = half_floor(r_c2.pos_y, r_c0.pos_y);
                n_mid[2][2] = half_floor(r_c2.pos_z, r_c0.pos_z);
                n_nsel = 2'd0;
                n_j = '0;
                n_state = r_sph_s ? ST_LOADV : ST_CROSS;
            end
            ST_LOADV: begin
                for (int i = 0; i < 3; i++) n_v[i] = VW'(r_mid[r_nsel][i]);
                n_state = ST_NABS;
            end
            ST_NABS: begin
                for (int i = 0; i < 3; i++) begin
                    n_mag[i] = MW'(mag[i] >> kk);
                    n_neg[i] = r_v[i][VW-1];
                end
                n_s = '0;
                n_j = '0;
                n_idx = 2'd0;
                n_state = ST_NSQ;
            end
            ST_NSQ: begin
                // product is registered and arrives in the cycle after its operand
                if (r_j != '0) n_s = s_fin;
                if (r_idx != 2'd2) n_idx = r_idx + 2'd1;
                n_j = r_j + J_W'(1);
                if (r_j == J_W'(3)) begin
                    n_j = '0;
                    n_rem = '0;
                    n_root = '0;
                    if (s_fin == '0) begin
                        for (int i = 0; i < 3; i++) n_nout[i] = '0;
                        n_state = ST_NDONE;
                    end else begin
                        n_state = ST_NSQRT;
                    end
                end
            end
            ST_NSQRT: begin
                if (sq_t >= sq_trial) begin
                    n_rem = 34'(sq_t - sq_trial);
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_rem = 34'(sq_t);
                    n_root = {r_root[30:0], 1'b0};
                end
                n_s = {r_s[61:0], 2'b00};
                n_j = r_j + J_W'(1);
                if (r_j == J_W'(31)) begin
                    n_j = '0;
                    n_idx = 2'd0;
                    n_num = NUM_W'(r_mag[0]) << FRAC_BITS;
                    n_quo = '0;
                    n_drem = '0;
                    n_state = ST_NDIV;
                end
            end
            ST_NDIV: begin
                n_drem = (dv_t >= {1'b0, r_root}) ? 32'(dv_t - {1'b0, r_root})
                                                  : 32'(dv_t);
                n_num = {r_num[NUM_W-2:0], 1'b0};
                n_quo = quo;
                n_j = r_j + J_W'(1);
                if (r_j == J_W'(NUM_W-1)) begin
                    n_nout[r_idx] = r_neg[r_idx] ? 16'(-qm) : 16'(qm);
                    n_j = '0;
                    n_quo = '0;
                    n_drem = '0;
                    if (r_idx == 2'd2) begin
                        n_state = ST_NDONE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                        n_num = NUM_W'(r_mag[r_idx + 2'd1]) << FRAC_BITS;
                    end
                end
            end
            ST_NDONE: begin
                if (r_nsel == SEL_NRM) begin
                    n_nrm = r_nout;
                    n_ek = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_mid[r_nsel] = r_nout;
                    n_nsel = r_nsel + 2'd1;
                    n_j = '0;
                    n_state = (r_nsel == 2'd2) ? ST_CROSS : ST_LOADV;
                end
            end
            ST_CROSS: begin
                // even product opens a component, odd one subtracts
                if (r_j[2:0] != 3'd0) begin
                    if (!pk[0]) n_v[pk[2:1]] = VW'(r_prod);
                    else        n_v[pk[2:1]] = r_v[pk[2:1]] - VW'(r_prod);
                end
                n_j = r_j + J_W'(1);
                if (r_j[2:0] == 3'd6) begin
                    n_nsel = SEL_NRM;
                    n_state = ST_NABS;
                end
            end
            ST_EMIT: begin
                if (o_out.ready) begin
                    n_vnum = r_vnum + VERTEX_NUMBER_BITS'(1);
                    n_ek = r_ek + 3'd1;
                    if (r_ek == 3'd5) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_sphere <= 1'b0;
            r_vnum   <= '0;
            r_ek     <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sphere <= n_sphere;
            r_vnum   <= n_vnum;
            r_ek     <= n_ek;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sph_s <= n_sph_s;
        r_c0 <= n_c0; r_c1 <= n_c1; r_c2 <= n_c2;
        r_mid <= n_mid; r_nrm <= n_nrm; r_nout <= n_nout; r_v <= n_v;
        r_mag <= n_mag; r_neg <= n_neg; r_nsel <= n_nsel; r_idx <= n_idx;
        r_j <= n_j; r_s <= n_s; r_rem <= n_rem; r_root <= n_root;
        r_num <= n_num; r_quo <= n_quo; r_drem <= n_drem;
        r_prod <= w_prod;
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = (r_state == ST_EMIT);

    always_comb begin
        tms_pkg::t_in_item c;
        c = r_c0;
        case (r_ek)
            3'd0: c = r_c0;
            3'd1: c = r_c1;
            3'd2: c = r_c2;
            default: c = r_c0;
        endcase
        o_out.data.vertex_number    = 16'(r_vnum);
        o_out.data.last_of_triangle = (r_ek == 3'd5);
        if (r_ek < 3'd3) begin
            o_out.data.out_pos_x = c.pos_x;
            o_out.data.out_pos_y = c.pos_y;
            o_out.data.out_pos_z = c.pos_z;
            o_out.data.out_nrm_x = c.nrm_x;
            o_out.data.out_nrm_y = c.nrm_y;
            o_out.data.out_nrm_z = c.nrm_z;
            o_out.data.out_tex_u = c.tex_u;
            o_out.data.out_tex_v = c.tex_v;
        end else begin
            o_out.data.out_pos_x = r_mid[2'(r_ek - 3'd3)][0];
            o_out.data.out_pos_y = r_mid[2'(r_ek - 3'd3)][1];
            o_out.data.out_pos_z = r_mid[2'(r_ek - 3'd3)][2];
            o_out.data.out_nrm_x = r_nrm[0];
            o_out.data.out_nrm_y = r_nrm[1];
            o_out.data.out_nrm_z = r_nrm[2];
            o_out.data.out_tex_u = '0;
            o_out.data.out_tex_v = '0;
        end
    end

    `TMS_ASSERT_NOW(a_no_in_during_out, i_clk, i_rst_n, i_in.ready, !o_out.valid, "input open while emitting")
    `TMS_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.data.last_of_triangle, o_out.valid, "vertex burst broken")
    `TMS_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, o_out.valid && o_out.ready && o_out.data.last_of_triangle, i_in.ready && (r_cnt == 2'd0), "not idle after last vertex")

endmodule
